FILE: design/v3alu_pkg.sv
`default_nettype none

package v3alu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int SUM_BITS  = WORD_BITS + 1;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int WIDE_BITS = PROD_BITS + 2;

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_SUB   = 3'd1,
    FN_SCALE = 3'd2,
    FN_DOT   = 3'd3,
    FN_CROSS = 3'd4
  } func_t;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;

  typedef struct packed {
    logic [2:0] func;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      scale_factor;
  } in_t;

  typedef struct packed {
    word_t res_x;
    word_t res_y;
    word_t res_z;
    word_t dot_value;
    logic  saturated;
  } out_t;

  // products and exact sums leaving the multiplier stages
  typedef struct packed {
    logic            valid;
    logic [2:0]      func;
    sum_t  [2:0]     sum;
    prod_t [2:0]     pa;
    prod_t [2:0]     pb;
  } mul_t;

  // shifted exact values ahead of saturation
  typedef struct packed {
    logic        valid;
    wide_t [2:0] vec;
    wide_t       dot;
  } comb_t;

endpackage

`default_nettype wire

FILE: design/v3alu_mul.sv
`default_nettype none

module v3alu_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire v3alu_pkg::in_t    in_data,
  output v3alu_pkg::mul_t        mul_out
);

  // operand select stage
  logic                   valid1_r;
  logic [2:0]             func1_r;
  v3alu_pkg::sum_t        sum1_r [3];
  v3alu_pkg::word_t       opa1_r [3];
  v3alu_pkg::word_t       opb1_r [3];
  v3alu_pkg::word_t       opc1_r [3];
  v3alu_pkg::word_t       opd1_r [3];

  v3alu_pkg::sum_t        sum1_nxt [3];
  v3alu_pkg::word_t       opa1_nxt [3];
  v3alu_pkg::word_t       opb1_nxt [3];
  v3alu_pkg::word_t       opc1_nxt [3];
  v3alu_pkg::word_t       opd1_nxt [3];

  // product stage
  logic                   valid2_r;
  logic [2:0]             func2_r;
  v3alu_pkg::sum_t        sum2_r [3];
  v3alu_pkg::prod_t       pa2_r [3];
  v3alu_pkg::prod_t       pb2_r [3];

  v3alu_pkg::word_t       av [3];
  v3alu_pkg::word_t       bv [3];

  always_comb begin
    av[0] = in_data.a_x;
    av[1] = in_data.a_y;
    av[2] = in_data.a_z;
    bv[0] = in_data.b_x;
    bv[1] = in_data.b_y;
    bv[2] = in_data.b_z;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_data.func == v3alu_pkg::FN_SUB) begin
        sum1_nxt[i] = v3alu_pkg::sum_t'(av[i]) - v3alu_pkg::sum_t'(bv[i]);
      end else begin
        sum1_nxt[i] = v3alu_pkg::sum_t'(av[i]) + v3alu_pkg::sum_t'(bv[i]);
      end
      opa1_nxt[i] = av[i];
      opb1_nxt[i] = bv[i];
      opc1_nxt[i] = '0;
      opd1_nxt[i] = '0;
    end
    unique case (in_data.func)
      v3alu_pkg::FN_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opb1_nxt[i] = in_data.scale_factor;
        end
      end
      v3alu_pkg::FN_CROSS: begin
        opa1_nxt[0] = av[1]; opb1_nxt[0] = bv[2];
        opc1_nxt[0] = av[2]; opd1_nxt[0] = bv[1];
        opa1_nxt[1] = av[2]; opb1_nxt[1] = bv[0];
        opc1_nxt[1] = av[0]; opd1_nxt[1] = bv[2];
        opa1_nxt[2] = av[0]; opb1_nxt[2] = bv[1];
        opc1_nxt[2] = av[1]; opd1_nxt[2] = bv[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    func1_r <= in_data.func;
    func2_r <= func1_r;
    for (int i = 0; i < 3; i++) begin
      sum1_r[i] <= sum1_nxt[i];
      opa1_r[i] <= opa1_nxt[i];
      opb1_r[i] <= opb1_nxt[i];
      opc1_r[i] <= opc1_nxt[i];
      opd1_r[i] <= opd1_nxt[i];
      sum2_r[i] <= sum1_r[i];
      pa2_r[i]  <= v3alu_pkg::prod_t'(opa1_r[i]) * v3alu_pkg::prod_t'(opb1_r[i]);
      pb2_r[i]  <= v3alu_pkg::prod_t'(opc1_r[i]) * v3alu_pkg::prod_t'(opd1_r[i]);
    end
  end

  always_comb begin
    mul_out.valid = valid2_r;
    mul_out.func  = func2_r;
    for (int i = 0; i < 3; i++) begin
      mul_out.sum[i] = sum2_r[i];
      mul_out.pa[i]  = pa2_r[i];
      mul_out.pb[i]  = pb2_r[i];
    end
  end

endmodule

`default_nettype wire

FILE: design/v3alu_comb.sv
`default_nettype none

module v3alu_comb (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire v3alu_pkg::mul_t   mul_in,
  output v3alu_pkg::comb_t       comb_out
);

  logic                valid3_r;
  v3alu_pkg::wide_t    vec3_r [3];
  v3alu_pkg::wide_t    dpart3_r;
  v3alu_pkg::wide_t    dlast3_r;

  v3alu_pkg::wide_t    vec3_nxt [3];
  v3alu_pkg::wide_t    dpart3_nxt;
  v3alu_pkg::wide_t    dlast3_nxt;

  logic                valid4_r;
  v3alu_pkg::wide_t    vec4_r [3];
  v3alu_pkg::wide_t    dot4_r;

  v3alu_pkg::wide_t    ta [3];
  v3alu_pkg::wide_t    tb [3];
  v3alu_pkg::wide_t    dot_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ta[i] = v3alu_pkg::wide_t'($signed(mul_in.pa[i]));
      tb[i] = v3alu_pkg::wide_t'($signed(mul_in.pb[i]));
    end
  end

  always_comb begin
    dpart3_nxt = '0;
    dlast3_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      vec3_nxt[i] = '0;
    end
    unique case (mul_in.func) inside
      v3alu_pkg::FN_ADD, v3alu_pkg::FN_SUB: begin
        for (int i = 0; i < 3; i++) begin
          vec3_nxt[i] = v3alu_pkg::wide_t'($signed(mul_in.sum[i]));
        end
      end
      v3alu_pkg::FN_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          vec3_nxt[i] = ta[i] >>> v3alu_pkg::FRAC_BITS;
        end
      end
      v3alu_pkg::FN_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          vec3_nxt[i] = (ta[i] - tb[i]) >>> v3alu_pkg::FRAC_BITS;
        end
      end
      v3alu_pkg::FN_DOT: begin
        dpart3_nxt = ta[0] + ta[1];
        dlast3_nxt = ta[2];
      end
      default: begin
      end
    endcase
  end

  assign dot_full = dpart3_r + dlast3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid3_r <= 1'b0;
      valid4_r <= 1'b0;
    end else begin
      valid3_r <= mul_in.valid;
      valid4_r <= valid3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      vec3_r[i] <= vec3_nxt[i];
      vec4_r[i] <= vec3_r[i];
    end
    dpart3_r <= dpart3_nxt;
    dlast3_r <= dlast3_nxt;
    dot4_r   <= dot_full >>> v3alu_pkg::FRAC_BITS;
  end

  always_comb begin
    comb_out.valid = valid4_r;
    comb_out.dot   = dot4_r;
    for (int i = 0; i < 3; i++) begin
      comb_out.vec[i] = vec4_r[i];
    end
  end

endmodule

`default_nettype wire

FILE: design/v3alu_sat.sv
`default_nettype none

module v3alu_sat (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire v3alu_pkg::comb_t  comb_in,
  output logic                   sat_valid,
  output v3alu_pkg::out_t        sat_data
);

  localparam int W = v3alu_pkg::WORD_BITS;
  localparam int V = v3alu_pkg::WIDE_BITS;

  logic               valid5_r;
  v3alu_pkg::out_t    data5_r;
  v3alu_pkg::out_t    data5_nxt;

  v3alu_pkg::wide_t   val [4];
  v3alu_pkg::word_t   clip [4];
  logic [3:0]         over;
  logic [V-W:0]       hi;

  always_comb begin
    val[0] = comb_in.vec[0];
    val[1] = comb_in.vec[1];
    val[2] = comb_in.vec[2];
    val[3] = comb_in.dot;
    for (int i = 0; i < 4; i++) begin
      hi      = val[i][V-1:W-1];
      over[i] = !((&hi) || !(|hi));
      if (!over[i]) begin
        clip[i] = val[i][W-1:0];
      end else if (val[i][V-1]) begin
        clip[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        clip[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
    data5_nxt.res_x     = clip[0];
    data5_nxt.res_y     = clip[1];
    data5_nxt.res_z     = clip[2];
    data5_nxt.dot_value = clip[3];
    data5_nxt.saturated = |over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid5_r <= 1'b0;
    end else begin
      valid5_r <= comb_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    data5_r <= data5_nxt;
  end

  assign sat_valid = valid5_r;
  assign sat_data  = data5_r;

endmodule

`default_nettype wire

FILE: design/vector3_alu.sv
// Fixed-point three-component vector unit: add, subtract, scale, dot and cross
// product on signed Q16.16 words; product results are shifted, and all results
// are saturated and flagged. Fully pipelined: one transfer can start every
// clock cycle and busy is always low. Each result appears on out_data with
// out_valid high for exactly one cycle, after the operand select, multiply,
// combine, dot final add and saturate stages, and the receiver cannot stall it.
`default_nettype none

module vector3_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire v3alu_pkg::in_t    in_data,
  output logic                   out_valid,
  output v3alu_pkg::out_t        out_data
);

  v3alu_pkg::mul_t   mul_s;
  v3alu_pkg::comb_t  comb_s;
  logic              in_fire;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  v3alu_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .in_data  (in_data),
    .mul_out  (mul_s)
  );

  v3alu_comb u_comb (
    .clk      (clk),
    .rst_n    (rst_n),
    .mul_in   (mul_s),
    .comb_out (comb_s)
  );

  v3alu_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .comb_in   (comb_s),
    .sat_valid (out_valid),
    .sat_data  (out_data)
  );

endmodule

`default_nettype wire
